### hdl/ldl_pkg.sv
`timescale 1ns / 1ps
package ldl_pkg;

  localparam int MAG_W  = 24;   // normalized direction magnitude
  localparam int LEN_W  = 50;   // squared length
  localparam int ROOT_W = 25;   // floor(sqrt(len2))
  localparam int PMAG_W = 41;   // |n . d'|
  localparam int F_W    = 20;   // facing factor, q0.16 with headroom
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_LIGHT_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIGHT_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIGHT_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_R  = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_G  = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN_B  = 3'd5;

  // 255 * 65536 and ceil(2^32 / 255)
  localparam logic [27:0] SAT_LIM   = 28'd16711680;
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ldl_color_t;

  typedef struct packed {
    logic              lit;
    logic [PMAG_W-1:0] pmag;
    ldl_color_t        col;
  } ldl_sqrt_side_t;

  typedef struct packed {
    logic       lit;
    ldl_color_t col;
  } ldl_div_side_t;

endpackage

### hdl/ldl_vec.sv
`timescale 1ns / 1ps
module ldl_vec import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  input  logic               is_plane,
  input  ldl_color_t         col_in,
  input  logic signed [31:0] light_x,
  input  logic signed [31:0] light_y,
  input  logic signed [31:0] light_z,
  output logic               out_v,
  output logic [LEN_W-1:0]   len2,
  output logic [PMAG_W-1:0]  pmag,
  output ldl_color_t         col_out,
  output logic               lit
);

  logic signed [15:0] n_in [3];
  logic signed [31:0] h_in [3];
  logic signed [31:0] l_in [3];

  assign n_in[0] = normal_x;
  assign n_in[1] = normal_y;
  assign n_in[2] = normal_z;
  assign h_in[0] = hit_x;
  assign h_in[1] = hit_y;
  assign h_in[2] = hit_z;
  assign l_in[0] = light_x;
  assign l_in[1] = light_y;
  assign l_in[2] = light_z;

  logic [6:0] v_r;

  // stage 1: difference
  logic signed [32:0] d1_r [3];
  logic signed [15:0] n1_r [3];
  logic               pl1_r;
  ldl_color_t         col1_r;
  // stage 2: sign and magnitude
  logic [32:0]        mag2_r [3];
  logic               neg2_r [3];
  logic signed [15:0] n2_r [3];
  logic               pl2_r;
  ldl_color_t         col2_r;
  // stage 3: leading one of the largest magnitude
  logic [32:0]        mag3_r [3];
  logic               neg3_r [3];
  logic signed [15:0] n3_r [3];
  logic               pl3_r;
  ldl_color_t         col3_r;
  logic               rsh3_r;
  logic [4:0]         amt3_r;
  logic               zero3_r;
  // stage 4: normalized magnitudes
  logic [MAG_W-1:0]   mag4_r [3];
  logic               neg4_r [3];
  logic signed [15:0] n4_r [3];
  logic               pl4_r;
  ldl_color_t         col4_r;
  logic               zero4_r;
  // stage 5: squares and products
  logic [2*MAG_W-1:0] sq5_r [3];
  logic signed [40:0] pr5_r [3];
  logic               pl5_r;
  ldl_color_t         col5_r;
  logic               zero5_r;
  // stage 6: sums
  logic [LEN_W-1:0]   len6_r;
  logic signed [41:0] p6_r;
  logic               pl6_r;
  ldl_color_t         col6_r;
  logic               zero6_r;
  // stage 7: facing test
  logic [LEN_W-1:0]   len7_r;
  logic [PMAG_W-1:0]  pmag7_r;
  logic               lit7_r;
  ldl_color_t         col7_r;

  logic [32:0]        or_mag;
  logic [5:0]         lead;
  logic signed [MAG_W:0] sm [3];

  always_comb begin
    or_mag = mag2_r[0] | mag2_r[1] | mag2_r[2];
    lead   = 6'd0;
    for (int b = 0; b < 33; b++) begin
      if (or_mag[b]) begin
        lead = 6'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[i] = neg4_r[i] ? -$signed({1'b0, mag4_r[i]}) : $signed({1'b0, mag4_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= {h_in[i][31], h_in[i]} - {l_in[i][31], l_in[i]};
        n1_r[i]  <= n_in[i];
        mag2_r[i] <= d1_r[i][32] ? 33'(-d1_r[i]) : 33'(d1_r[i]);
        neg2_r[i] <= d1_r[i][32];
        n2_r[i]  <= n1_r[i];
        mag3_r[i] <= mag2_r[i];
        neg3_r[i] <= neg2_r[i];
        n3_r[i]  <= n2_r[i];
        mag4_r[i] <= rsh3_r ? MAG_W'(mag3_r[i] >> amt3_r) : MAG_W'(mag3_r[i] << amt3_r);
        neg4_r[i] <= neg3_r[i];
        n4_r[i]  <= n3_r[i];
        sq5_r[i] <= mag4_r[i] * mag4_r[i];
        pr5_r[i] <= 41'(n4_r[i]) * 41'(sm[i]);
      end
      pl1_r  <= is_plane;
      col1_r <= col_in;
      pl2_r  <= pl1_r;
      col2_r <= col1_r;
      pl3_r  <= pl2_r;
      col3_r <= col2_r;
      zero3_r <= (or_mag == '0);
      rsh3_r  <= (lead >= 6'd23);
      amt3_r  <= (lead >= 6'd23) ? 5'(lead - 6'd23) : 5'(6'd23 - lead);
      pl4_r   <= pl3_r;
      col4_r  <= col3_r;
      zero4_r <= zero3_r;
      pl5_r   <= pl4_r;
      col5_r  <= col4_r;
      zero5_r <= zero4_r;
      len6_r  <= LEN_W'(sq5_r[0]) + LEN_W'(sq5_r[1]) + LEN_W'(sq5_r[2]);
      p6_r    <= 42'(pr5_r[0]) + 42'(pr5_r[1]) + 42'(pr5_r[2]);
      pl6_r   <= pl5_r;
      col6_r  <= col5_r;
      zero6_r <= zero5_r;
      // planes are two-sided: a negative product counts with its sign flipped
      lit7_r  <= !zero6_r && ((!p6_r[41] && p6_r != '0) || (pl6_r && p6_r[41]));
      pmag7_r <= p6_r[41] ? PMAG_W'(-p6_r) : PMAG_W'(p6_r);
      len7_r  <= len6_r;
      col7_r  <= col6_r;
    end
  end

  assign out_v   = v_r[6];
  assign len2    = len7_r;
  assign pmag    = pmag7_r;
  assign col_out = col7_r;
  assign lit     = lit7_r;

endmodule

### hdl/ldl_isqrt.sv
`timescale 1ns / 1ps
module ldl_isqrt import ldl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [LEN_W-1:0] len2,
  input  ldl_sqrt_side_t   side_in,
  output logic             out_v,
  output logic [ROOT_W-1:0] root,
  output ldl_sqrt_side_t   side_out
);

  localparam int RW = ROOT_W + 2;

  logic                v_r    [ROOT_W];
  logic [LEN_W-1:0]    x_r    [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [RW-1:0]       rem_r  [ROOT_W];
  ldl_sqrt_side_t      side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic              pv;
    logic [LEN_W-1:0]  px;
    logic [ROOT_W-1:0] proot;
    logic [RW-1:0]     prem;
    ldl_sqrt_side_t    pside;
    logic [RW-1:0]     remsh;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv    = in_v;
      assign px    = len2;
      assign proot = '0;
      assign prem  = '0;
      assign pside = side_in;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign px    = x_r[k-1];
      assign proot = root_r[k-1];
      assign prem  = rem_r[k-1];
      assign pside = side_r[k-1];
    end

    // one root bit per stage from the next pair of radicand bits
    assign remsh = {prem[RW-3:0], px[2*I+1 -: 2]};
    assign trial = {proot, 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= px;
        root_r[k] <= {proot[ROOT_W-2:0], ge};
        rem_r[k]  <= ge ? (remsh - trial) : remsh;
        side_r[k] <= pside;
      end
    end
  end

  assign out_v    = v_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule

### hdl/ldl_div.sv
`timescale 1ns / 1ps
module ldl_div import ldl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [PMAG_W-1:0] pmag,
  input  logic [ROOT_W-1:0] root,
  input  ldl_div_side_t     side_in,
  output logic              out_v,
  output logic [F_W-1:0]    quo,
  output ldl_div_side_t     side_out
);

  localparam int NW = PMAG_W + 2;

  logic              v_r    [F_W];
  logic [NW-1:0]     n_r    [F_W];
  logic [ROOT_W-1:0] d_r    [F_W];
  logic [ROOT_W-1:0] rem_r  [F_W];
  logic [F_W-1:0]    q_r    [F_W];
  ldl_div_side_t     side_r [F_W];

  logic [NW-1:0] num;
  assign num = {pmag, 2'b00};

  for (genvar k = 0; k < F_W; k++) begin : g_stage
    localparam int J = F_W - 1 - k;
    logic              pv;
    logic [NW-1:0]     pn;
    logic [ROOT_W-1:0] pd;
    logic [ROOT_W-1:0] prem;
    logic [F_W-1:0]    pq;
    ldl_div_side_t     pside;
    logic [ROOT_W:0]   rem2;
    logic              ge;

    if (k == 0) begin : g_first
      // high dividend bits stay below the root, so they seed the remainder
      assign pv    = in_v;
      assign pn    = num;
      assign pd    = root;
      assign prem  = ROOT_W'(num[NW-1:F_W]);
      assign pq    = '0;
      assign pside = side_in;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign pn    = n_r[k-1];
      assign pd    = d_r[k-1];
      assign prem  = rem_r[k-1];
      assign pq    = q_r[k-1];
      assign pside = side_r[k-1];
    end

    assign rem2 = {prem, pn[J]};
    assign ge   = (rem2 >= {1'b0, pd});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= pn;
        d_r[k]    <= pd;
        rem_r[k]  <= ge ? ROOT_W'(rem2 - {1'b0, pd}) : ROOT_W'(rem2);
        q_r[k]    <= {pq[F_W-2:0], ge};
        side_r[k] <= pside;
      end
    end
  end

  assign out_v    = v_r[F_W-1];
  assign quo      = q_r[F_W-1];
  assign side_out = side_r[F_W-1];

endmodule

### hdl/ldl_color.sv
`timescale 1ns / 1ps
module ldl_color import ldl_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [F_W-1:0] fac,
  input  ldl_div_side_t  side_in,
  input  logic [15:0]    gain_red,
  input  logic [15:0]    gain_green,
  input  logic [15:0]    gain_blue,
  output logic           out_v,
  output logic [15:0]    add_red,
  output logic [15:0]    add_green,
  output logic [15:0]    add_blue,
  output logic           lit
);

  logic [15:0] gain [3];
  logic [7:0]  obj1 [3];

  assign gain[0] = gain_red;
  assign gain[1] = gain_green;
  assign gain[2] = gain_blue;

  logic [2:0]        v_r;
  logic [F_W+15:0]   pg1_r [3];
  ldl_div_side_t     side1_r;
  logic [F_W+23:0]   x2_r  [3];
  logic              lit2_r;
  logic [48:0]       qm3_r [3];
  logic              sat3_r [3];
  logic              lit3_r;
  logic [27:0]       y2 [3];
  logic [15:0]       q3 [3];

  assign obj1[0] = side1_r.col.red;
  assign obj1[1] = side1_r.col.green;
  assign obj1[2] = side1_r.col.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y2[c] = 28'(x2_r[c] >> 16);
      q3[c] = sat3_r[c] ? 16'hFFFF : qm3_r[c][47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_in;
      lit2_r  <= side1_r.lit;
      lit3_r  <= lit2_r;
      for (int c = 0; c < 3; c++) begin
        pg1_r[c]  <= gain[c] * fac;
        x2_r[c]   <= pg1_r[c] * obj1[c];
        // divide by 255 through the reciprocal, exact below the clamp level
        sat3_r[c] <= (y2[c] >= SAT_LIM);
        qm3_r[c]  <= y2[c][23:0] * RECIP_255;
      end
    end
  end

  assign out_v     = v_r[2];
  assign lit       = lit3_r;
  assign add_red   = lit3_r ? q3[0] : 16'd0;
  assign add_green = lit3_r ? q3[1] : 16'd0;
  assign add_blue  = lit3_r ? q3[2] : 16'd0;

endmodule

### hdl/lambert_diffuse_light_term_core.sv
`timescale 1ns / 1ps
// lambertian diffuse term for one light, one surface hit per transfer
// input channel: in_valid / in_stall with the normal (q1.14), hit point (q16.16),
//   plane flag and object color bytes
// output channel: out_valid / out_stall with red, green and blue contributions
//   (q0.16, saturated) and the lit flag
// config: cfg_valid / cfg_ready with cfg_index 0..5 (light x, y, z, gain r, g, b)
//   and cfg_data; cfg_ready is always high; write only while no item is in flight
// the pipeline has 7 vector stages, 25 square root stages (one root bit each),
//   20 divider stages (one quotient bit each), 3 color stages and the output
//   register; it takes one item per cycle sustained while the skid register is
//   empty
// a stalled output holds its item and a second one is caught in a skid register;
//   in_stall rises only while that skid register is full, and the whole pipeline
//   freezes with it, so nothing is lost or repeated
// reset (synchronous, rst_n low) empties the pipeline and clears the light
//   and gain registers to 0
module lambert_diffuse_light_term_core import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  input  logic               in_is_plane,
  input  logic [7:0]         in_obj_red,
  input  logic [7:0]         in_obj_green,
  input  logic [7:0]         in_obj_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_add_red,
  output logic [15:0]        out_add_green,
  output logic [15:0]        out_add_blue,
  output logic               out_lit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        lit;
  } ldl_result_t;

  logic signed [31:0] light_x_r, light_y_r, light_z_r;
  logic [15:0]        gain_r_r, gain_g_r, gain_b_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= '0;
      light_y_r <= '0;
      light_z_r <= '0;
      gain_r_r  <= '0;
      gain_g_r  <= '0;
      gain_b_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIGHT_X: light_x_r <= cfg_data;
        REG_LIGHT_Y: light_y_r <= cfg_data;
        REG_LIGHT_Z: light_z_r <= cfg_data;
        REG_GAIN_R:  gain_r_r  <= cfg_data[15:0];
        REG_GAIN_G:  gain_g_r  <= cfg_data[15:0];
        REG_GAIN_B:  gain_b_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;
  logic out_v_r;
  ldl_result_t out_r, skid_r, tail;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  ldl_color_t     col_in;
  logic           vec_v;
  logic [LEN_W-1:0]  vec_len2;
  logic [PMAG_W-1:0] vec_pmag;
  ldl_color_t     vec_col;
  logic           vec_lit;
  ldl_sqrt_side_t sq_side_in, sq_side_out;
  logic           sq_v;
  logic [ROOT_W-1:0] sq_root;
  ldl_div_side_t  dv_side_in, dv_side_out;
  logic           dv_v;
  logic [F_W-1:0] dv_quo;
  logic           tail_v;

  assign col_in = '{red: in_obj_red, green: in_obj_green, blue: in_obj_blue};

  ldl_vec u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid && en),
    .normal_x (in_normal_x),
    .normal_y (in_normal_y),
    .normal_z (in_normal_z),
    .hit_x    (in_hit_x),
    .hit_y    (in_hit_y),
    .hit_z    (in_hit_z),
    .is_plane (in_is_plane),
    .col_in   (col_in),
    .light_x  (light_x_r),
    .light_y  (light_y_r),
    .light_z  (light_z_r),
    .out_v    (vec_v),
    .len2     (vec_len2),
    .pmag     (vec_pmag),
    .col_out  (vec_col),
    .lit      (vec_lit)
  );

  assign sq_side_in = '{lit: vec_lit, pmag: vec_pmag, col: vec_col};

  ldl_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vec_v),
    .len2     (vec_len2),
    .side_in  (sq_side_in),
    .out_v    (sq_v),
    .root     (sq_root),
    .side_out (sq_side_out)
  );

  assign dv_side_in = '{lit: sq_side_out.lit, col: sq_side_out.col};

  ldl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sq_v),
    .pmag     (sq_side_out.pmag),
    .root     (sq_root),
    .side_in  (dv_side_in),
    .out_v    (dv_v),
    .quo      (dv_quo),
    .side_out (dv_side_out)
  );

  ldl_color u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (dv_v),
    .fac        (dv_quo),
    .side_in    (dv_side_out),
    .gain_red   (gain_r_r),
    .gain_green (gain_g_r),
    .gain_blue  (gain_b_r),
    .out_v      (tail_v),
    .add_red    (tail.red),
    .add_green  (tail.green),
    .add_blue   (tail.blue),
    .lit        (tail.lit)
  );

  logic out_take;
  assign out_take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (tail_v) begin
      if (out_v_r && !out_take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (tail_v) begin
      if (out_v_r && !out_take) begin
        skid_r <= tail;
      end else begin
        out_r <= tail;
      end
    end
  end

  assign out_valid     = out_v_r;
  assign out_add_red   = out_r.red;
  assign out_add_green = out_r.green;
  assign out_add_blue  = out_r.blue;
  assign out_lit       = out_r.lit;

endmodule

### test/lambert_diffuse_light_term_checker.sv
`timescale 1ns / 1ps
module lambert_diffuse_light_term_checker import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  input  logic               in_is_plane,
  input  logic [7:0]         in_obj_red,
  input  logic [7:0]         in_obj_green,
  input  logic [7:0]         in_obj_blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_add_red,
  input  logic [15:0]        out_add_green,
  input  logic [15:0]        out_add_blue,
  input  logic               out_lit,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 lit_seen
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        lit;
  } shade_t;

  shade_t shade_q[$];
  logic signed [31:0] light_pos [3];
  logic [15:0] gain_r, gain_g, gain_b;

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] tint(logic [15:0] g, logic [63:0] f, logic [7:0] c);
    logic [63:0] v;
    v = (64'(g) * f * 64'(c)) / 64'(SAT_LIM);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic shade_t shade_hit(logic signed [15:0] nrm [3],
                                       logic signed [31:0] hit [3],
                                       logic plane, logic [7:0] cr,
                                       logic [7:0] cg, logic [7:0] cb);
    shade_t s;
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] m, len2, r, f;
    logic signed [63:0] d, p;
    s = '0;
    m = 0;
    len2 = 0;
    p = 0;
    for (int i = 0; i < 3; i++) begin
      d = 64'(hit[i]) - 64'(light_pos[i]);
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return s;
    while (m >= (64'd1 << 24)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 23)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) begin
      len2 = len2 + mag[i] * mag[i];
      p = p + 64'(nrm[i]) * (neg[i] ? -$signed(mag[i]) : $signed(mag[i]));
    end
    r = root_floor(len2);
    if (p <= 0 && plane) p = -p;
    if (p <= 0 || r == 0) return s;
    f = (p * 4) / r;
    s.red = tint(gain_r, f, cr);
    s.green = tint(gain_g, f, cg);
    s.blue = tint(gain_b, f, cb);
    s.lit = 1'b1;
    return s;
  endfunction

  assign pending = shade_q.size();

  always @(posedge clk) begin
    shade_t want, got;
    logic signed [15:0] nrm [3];
    logic signed [31:0] hit [3];
    if (!rst_n) begin
      light_pos = '{0, 0, 0};
      gain_r = 0;
      gain_g = 0;
      gain_b = 0;
      fail_count <= 0;
      lit_seen <= 0;
      shade_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIGHT_X: light_pos[0] = cfg_data;
          REG_LIGHT_Y: light_pos[1] = cfg_data;
          REG_LIGHT_Z: light_pos[2] = cfg_data;
          REG_GAIN_R:  gain_r = cfg_data[15:0];
          REG_GAIN_G:  gain_g = cfg_data[15:0];
          REG_GAIN_B:  gain_b = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        nrm = '{in_normal_x, in_normal_y, in_normal_z};
        hit = '{in_hit_x, in_hit_y, in_hit_z};
        shade_q.push_back(shade_hit(nrm, hit, in_is_plane,
                                    in_obj_red, in_obj_green, in_obj_blue));
      end
      if (out_valid && !out_stall) begin
        got = '{out_add_red, out_add_green, out_add_blue, out_lit};
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected result exp none act %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = shade_q.pop_front();
          if (got.lit) lit_seen <= lit_seen + 1;
          if (got !== want) begin
            $display("%0t: mismatch exp r=%h g=%h b=%h lit=%b act r=%h g=%h b=%h lit=%b",
                     $time, want.red, want.green, want.blue, want.lit,
                     got.red, got.green, got.blue, got.lit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### test/lambert_diffuse_light_term_core_test.sv
`timescale 1ns / 1ps
module lambert_diffuse_light_term_core_test;
  import ldl_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, out_lit;
  logic signed [15:0] in_normal_x = 0, in_normal_y = 0, in_normal_z = 0;
  logic signed [31:0] in_hit_x = 0, in_hit_y = 0, in_hit_z = 0;
  logic in_is_plane = 0;
  logic [7:0] in_obj_red = 0, in_obj_green = 0, in_obj_blue = 0;
  logic [15:0] out_add_red, out_add_green, out_add_blue;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = REG_LIGHT_X;
  logic [31:0] cfg_data = 0;
  int fail_count, pending, lit_seen, hits_sent;
  bit hold_off = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  lambert_diffuse_light_term_core i_dut (.*);

  lambert_diffuse_light_term_checker i_check (.*);

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side stalls
  always @(posedge clk) begin
    int k;
    if (hold_off) out_stall <= 1'b1;
    else begin
      k = $urandom_range(0, 99);
      out_stall <= (k < 20) || (k < 22 && !out_stall) ? 1'b1 : (k < 24 ? out_stall : 1'b0);
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic send_hit(logic signed [15:0] nx, ny, nz, logic signed [31:0] hx, hy, hz,
                          logic pl, logic [7:0] cr, cg, cb, bit gaps);
    in_valid <= 1'b1;
    {in_normal_x, in_normal_y, in_normal_z} <= {nx, ny, nz};
    {in_hit_x, in_hit_y, in_hit_z} <= {hx, hy, hz};
    {in_is_plane, in_obj_red, in_obj_green, in_obj_blue} <= {pl, cr, cg, cb};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hits_sent++;
    if (gaps) begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] rand_normal();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom());
    if (k == 1) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  function automatic logic signed [31:0] rand_coord(logic signed [31:0] near);
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return $urandom();
    if (k < 3) return near + $signed(32'($urandom_range(0, 15))) - 8;
    if (k < 4) return near;
    return near + $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
  endfunction

  task automatic random_phase(int count, logic signed [31:0] lx, ly, lz);
    for (int i = 0; i < count; i++)
      send_hit(rand_normal(), rand_normal(), rand_normal(),
               rand_coord(lx), rand_coord(ly), rand_coord(lz),
               1'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()),
               8'($urandom()), 1'b1);
    in_valid <= 1'b0;
  endtask

  task automatic set_light(logic [31:0] x, y, z, logic [15:0] r, g, b);
    write_reg(REG_LIGHT_X, x);
    write_reg(REG_LIGHT_Y, y);
    write_reg(REG_LIGHT_Z, z);
    write_reg(REG_GAIN_R, {16'($urandom()), r});
    write_reg(REG_GAIN_G, 32'(g));
    write_reg(REG_GAIN_B, 32'(b));
  endtask

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic signed [31:0] lx, ly, lz;
    hits_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // zero registers: everything dark, direction zero at origin
    send_hit(0, 0, 16384, 0, 0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(0, 0, 16384, 0, 0, 32'sh10000, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    in_valid <= 1'b0;
    drain();
    set_light(0, 0, 32'sh000A_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // facing, back-facing sphere, back-facing plane, grazing, hit at the light, extremes
    send_hit(0, 0, -16384, 0, 0, 0, 1'b0, 8'hFF, 8'h80, 8'h00, 1'b0);
    send_hit(0, 0, 16384, 0, 0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(0, 0, 16384, 0, 0, 0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(16384, 0, 0, 0, 0, 0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(0, 0, -16384, 0, 0, 32'sh000A_0000, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(-16'sh8000, -16'sh8000, -16'sh8000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             -32'sh8000_0000, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -32'sh8000_0000, -32'sh8000_0000,
             32'sh7FFF_FFFF, 1'b0, 8'h01, 8'hFE, 8'h55, 1'b0);
    send_hit(1, 0, 0, -1, 0, 32'sh000A_0000, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(0, 0, -1, 32'sh7FFF_0000, 0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    in_valid <= 1'b0;
    drain();
    set_light(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001, 16'h0, 16'hFFFF);
    send_hit(16384, -16384, 16384, 0, 0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_hit(-16384, 16384, -16384, 0, 0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    in_valid <= 1'b0;
    drain();
    // random phases under several light settings
    for (int ph = 0; ph < 5; ph++) begin
      lx = $urandom();
      ly = $urandom();
      lz = $urandom();
      if (ph == 4) set_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             16'hFFFF, 16'h0000, 16'h8000);
      else set_light(lx, ly, lz, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      if (ph == 4) begin
        lx = 32'sh7FFF_FFFF; ly = -32'sh8000_0000; lz = 32'sh7FFF_FFFF;
      end
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_phase(205, lx, ly, lz);
      drain();
    end
    $display("%0d hits shaded across 8 light settings, %0d came out lit", hits_sent, lit_seen);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
